// ===== rtl/fba_pkg.sv =====
// shared constants and types for the file block allocator
package fba_pkg;
   localparam int NUM_BLOCKS      = 1024;
   localparam int NUM_FILES       = 64;
   localparam int MAX_FILE_BLOCKS = 64;
   localparam int BLOCK_BYTES     = 4096;

   localparam int BLK_W   = $clog2(NUM_BLOCKS);
   localparam int FILE_W  = 6;
   localparam int SIZE_W  = 19;
   localparam int CNT_W   = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int FREE_W  = $clog2(NUM_BLOCKS + 1);
   localparam int FIDX_W  = $clog2(NUM_FILES);
   localparam int LIDX_W  = $clog2(MAX_FILE_BLOCKS);
   localparam int SHIFT_W = $clog2(BLOCK_BYTES);
   localparam int WORD_W  = 32;
   localparam int NWORDS  = NUM_BLOCKS / WORD_W;
   localparam int WADDR_W = $clog2(NWORDS);

   localparam logic [1:0] ST_UNCHANGED = 2'd0;
   localparam logic [1:0] ST_RESIZED   = 2'd1;
   localparam logic [1:0] ST_NO_SPACE  = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   typedef struct packed {
      logic [1:0]       status;
      logic             block_valid;
      logic             block_freed;
      logic [BLK_W-1:0] block_number;
      logic             is_last;
   } result_type;
endpackage

// ===== rtl/file_block_allocator.sv =====
// top level: resize requests against a bitmap allocator held in memories
// Usage: a request (req_file_index, req_new_size) is accepted when req_valid
// is high and req_stall is low. Each request yields one or more result items
// on the rsp_ channel, the last one flagged by rsp_is_last; a growth or
// shrink gives one item per block taken or freed.
// Throughput: one request at a time; a new request is taken only once the
// last result item of the previous one has left the output register. A
// request passes through accept, state read and decision, then for each
// freed block a list read, a bitmap word read and the update, or for growth
// a read per full bitmap word skipped and an update per block taken, then a
// write back of size and count (and an output step for a blockless result);
// the registered reads of the bitmap and file list memories set these steps.
// Reset: a clearing pass over 64 entries (the larger of bitmap words and file
// entries) runs after reset; no request is accepted during it.
// Stall: a result waits in the output register while rsp_stall is high; the
// sequencer holds only where it would emit the next item, and the bitmap scan still skips full words meanwhile.
module file_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_file_index,
   input  logic [18:0] req_new_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_block_valid,
   output logic        rsp_block_freed,
   output logic [9:0]  rsp_block_number,
   output logic        rsp_is_last
);
   localparam int BW = fba_pkg::BLK_W;
   localparam int CW = fba_pkg::CNT_W;
   localparam int SW = fba_pkg::SIZE_W;
   localparam int WW = fba_pkg::WORD_W;
   localparam int AW = fba_pkg::WADDR_W;
   localparam int FW = fba_pkg::FIDX_W;
   localparam int LW = fba_pkg::LIDX_W;
   localparam int CLR_N = (fba_pkg::NWORDS > fba_pkg::NUM_FILES) ?
                          fba_pkg::NWORDS : fba_pkg::NUM_FILES;
   localparam int CLR_W = $clog2(CLR_N + 1);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2,
                          S_DECIDE = 4'd3, S_SCAN = 4'd4, S_SCANW = 4'd5,
                          S_SHR = 4'd6, S_SHRW = 4'd7, S_SHRB = 4'd8,
                          S_SHRB2 = 4'd9, S_DONE = 4'd10, S_OUT = 4'd11;

   // memories
   logic [WW-1:0] map_mem [fba_pkg::NWORDS];
   logic [SW-1:0] size_mem [fba_pkg::NUM_FILES];
   logic [CW-1:0] cnt_mem [fba_pkg::NUM_FILES];
   logic [BW-1:0] list_mem [fba_pkg::NUM_FILES * fba_pkg::MAX_FILE_BLOCKS];

   logic [3:0]  state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [5:0]  fidx_ff, fidx_in;
   logic [SW-1:0] size_ff, size_in;
   logic [CW-1:0] have_ff, have_in, want_ff, want_in;
   logic [FW-1:0] fa;
   logic [SW-1:0] size_rd_ff;
   logic [CW-1:0] cnt_rd_ff;
   logic [WW-1:0] word_rd_ff;
   logic [BW-1:0] list_rd_ff;
   logic [BW-1:0] blk_ff, blk_in;
   logic [AW:0]   waddr_ff, waddr_in;
   logic [fba_pkg::FREE_W-1:0] free_ff, free_in;
   logic          n_ff, n_in;
   logic          rv_ff, rv_in;
   fba_pkg::result_type res_ff, res_in;

   // memory control
   logic          map_we, size_we, cnt_we, list_we;
   logic [AW-1:0] map_wa, map_ra;
   logic [WW-1:0] map_wd;
   logic [FW-1:0] file_wa;
   logic [SW-1:0] size_wd;
   logic [CW-1:0] cnt_wd;
   logic [FW+LW-1:0] list_a;
   logic [BW-1:0] list_wd;

   logic rsp_free;
   logic [WW-1:0] lowbit;
   logic [$clog2(WW)-1:0] bitpos;
   logic [SW:0] want_full;
   logic [CW-1:0] need;

   assign rsp_free = !rv_ff || !rsp_stall;
   assign fa = fidx_ff[FW-1:0];
   assign lowbit = ~word_rd_ff & (word_rd_ff + 1'b1);
   assign want_full = ({1'b0, size_ff} + (SW+1)'(fba_pkg::BLOCK_BYTES - 1))
                      >> fba_pkg::SHIFT_W;
   assign need = want_ff - have_ff;

   always_comb begin
      bitpos = '0;
      for (int k = 0; k < WW; k++) begin
         if (lowbit[k]) bitpos = ($clog2(WW))'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      word_rd_ff <= map_mem[map_ra];
      if (size_we) size_mem[file_wa] <= size_wd;
      if (cnt_we) cnt_mem[file_wa] <= cnt_wd;
      size_rd_ff <= size_mem[fa];
      cnt_rd_ff <= cnt_mem[fa];
      if (list_we) list_mem[list_a] <= list_wd;
      list_rd_ff <= list_mem[list_a];
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      fidx_in = fidx_ff;
      size_in = size_ff;
      have_in = have_ff;
      want_in = want_ff;
      waddr_in = waddr_ff;
      blk_in = blk_ff;
      free_in = free_ff;
      n_in = n_ff;
      rv_in = rv_ff && rsp_stall;
      res_in = res_ff;
      map_we = 1'b0;
      map_wa = waddr_ff[AW-1:0];
      map_ra = waddr_ff[AW-1:0];
      map_wd = '0;
      size_we = 1'b0;
      cnt_we = 1'b0;
      file_wa = fa;
      size_wd = size_ff;
      cnt_wd = have_ff;
      list_we = 1'b0;
      list_a = {fa, have_ff[LW-1:0]};
      list_wd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            map_we = clr_ff < CLR_W'(fba_pkg::NWORDS);
            map_wa = clr_ff[AW-1:0];
            size_we = clr_ff < CLR_W'(fba_pkg::NUM_FILES);
            cnt_we = size_we;
            file_wa = clr_ff[FW-1:0];
            size_wd = '0;
            cnt_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               fidx_in = req_file_index;
               size_in = req_new_size;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_DECIDE;
         S_DECIDE: begin
            have_in = (cnt_rd_ff > CW'(fba_pkg::MAX_FILE_BLOCKS)) ?
                      CW'(fba_pkg::MAX_FILE_BLOCKS) : cnt_rd_ff;
            want_in = CW'(want_full);
            n_in = 1'b0;
            waddr_in = '0;
            res_in = '0;
            res_in.is_last = 1'b1;
            if (32'(fidx_ff) >= fba_pkg::NUM_FILES || size_ff == size_rd_ff) begin
               res_in.status = fba_pkg::ST_UNCHANGED;
               state_in = S_OUT;
            end else if (want_full > (SW+1)'(fba_pkg::MAX_FILE_BLOCKS)) begin
               res_in.status = fba_pkg::ST_TOO_LARGE;
               state_in = S_OUT;
            end else if (size_ff > size_rd_ff) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_SHR;
            end
         end
         S_SCAN: begin
            if (want_ff <= have_ff) begin
               state_in = S_DONE;
            end else if (!n_ff && fba_pkg::FREE_W'(need) > free_ff) begin
               res_in.status = fba_pkg::ST_NO_SPACE;
               state_in = S_OUT;
            end else if (waddr_ff == (AW+1)'(fba_pkg::NWORDS)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCANW;
            end
         end
         S_SCANW: begin
            // word read is ready; take its lowest free bit if output is free
            if (&word_rd_ff) begin
               waddr_in = waddr_ff + 1'b1;
               state_in = S_SCAN;
            end else if (rsp_free) begin
               map_we = 1'b1;
               map_wd = word_rd_ff | lowbit;
               list_we = 1'b1;
               list_wd = {waddr_ff[AW-1:0], bitpos};
               have_in = have_ff + 1'b1;
               free_in = free_ff - 1'b1;
               n_in = 1'b1;
               rv_in = 1'b1;
               res_in.status = fba_pkg::ST_RESIZED;
               res_in.block_valid = 1'b1;
               res_in.block_freed = 1'b0;
               res_in.block_number = {waddr_ff[AW-1:0], bitpos};
               res_in.is_last = (have_ff + 1'b1) == want_ff;
               state_in = ((have_ff + 1'b1) == want_ff) ? S_DONE : S_SCAN;
            end
         end
         S_SHR: begin
            if (have_ff <= want_ff) begin
               state_in = S_DONE;
            end else begin
               list_a = {fa, LW'(have_ff - 1'b1)};
               state_in = S_SHRW;
            end
         end
         S_SHRW: begin
            map_ra = list_rd_ff[BW-1:$clog2(WW)];
            waddr_in = {1'b0, list_rd_ff[BW-1:$clog2(WW)]};
            blk_in = list_rd_ff;
            state_in = S_SHRB;
         end
         S_SHRB: state_in = S_SHRB2;
         S_SHRB2: begin
            if (rsp_free) begin
               if (word_rd_ff[blk_ff[$clog2(WW)-1:0]]) begin
                  map_we = 1'b1;
                  map_wd = word_rd_ff;
                  map_wd[blk_ff[$clog2(WW)-1:0]] = 1'b0;
                  free_in = free_ff + 1'b1;
               end
               have_in = have_ff - 1'b1;
               n_in = 1'b1;
               rv_in = 1'b1;
               res_in.status = fba_pkg::ST_RESIZED;
               res_in.block_valid = 1'b1;
               res_in.block_freed = 1'b1;
               res_in.block_number = blk_ff;
               res_in.is_last = (have_ff - 1'b1) == want_ff;
               state_in = ((have_ff - 1'b1) == want_ff) ? S_DONE : S_SHR;
            end
         end
         S_DONE: begin
            size_we = 1'b1;
            cnt_we = 1'b1;
            if (n_ff) begin
               state_in = S_IDLE;
            end else begin
               res_in = '0;
               res_in.status = fba_pkg::ST_RESIZED;
               res_in.is_last = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         free_ff <= fba_pkg::FREE_W'(fba_pkg::NUM_BLOCKS);
         n_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         free_ff <= free_in;
         n_ff <= n_in;
      end
      fidx_ff <= fidx_in;
      size_ff <= size_in;
      have_ff <= have_in;
      want_ff <= want_in;
      waddr_ff <= waddr_in;
      blk_ff <= blk_in;
      res_ff <= res_in;
   end

   // a new request waits until the previous last item has left
   assign req_stall = state_ff != S_IDLE || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = res_ff.status;
   assign rsp_block_valid = res_ff.block_valid;
   assign rsp_block_freed = res_ff.block_freed;
   assign rsp_block_number = res_ff.block_number;
   assign rsp_is_last = res_ff.is_last;

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= fba_pkg::FREE_W'(fba_pkg::NUM_BLOCKS))
      else $error("free count above block total");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(res_ff))
      else $error("stalled result changed");
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("request taken during clear");
   a_blockless: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !res_ff.block_valid |-> res_ff.is_last)
      else $error("blockless result not last");
endmodule
